FILE: rtl/wlrf_pkg.sv
// Package for the rough-wall log-law bed friction block.
// Holds pipeline stage indices, fixed-point constants and register codes.
// No dependencies; imported by the top level and by its checker.
package wlrf_pkg;

  // Register indices on the configuration port.
  localparam logic [1:0] CFG_ENABLE  = 2'd0;
  localparam logic [1:0] CFG_LAYER   = 2'd1;
  localparam logic [1:0] CFG_IKARMAN = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  // Fixed-point constants.
  localparam logic [16:0] LF_ONE      = 17'd65536;
  localparam logic [15:0] LN2_Q16     = 16'd45426;
  localparam logic [16:0] IK_RESET    = 17'd10240;
  localparam logic [33:0] TERM_CAP    = 34'h200000000;

  // Pipeline geometry: stage indices and pipeline length.
  localparam int N_SQ      = 16;   // squaring stages of the log2 unit
  localparam int N_QBITS   = 35;   // quotient bits of the divider
  localparam int ST_LOG0   = 4;
  localparam int ST_DIFF   = ST_LOG0 + N_SQ;
  localparam int ST_CAP    = ST_DIFF + 6;
  localparam int ST_DIV0   = ST_CAP + 1;
  localparam int PIPE_LEN  = ST_DIV0 + N_QBITS;
  localparam int LATENCY   = PIPE_LEN + 1;

  typedef struct packed {
    logic        vneg;
    logic        bypass;
    logic        degen;
    logic [31:0] force_in;
  } ctl_t;

endpackage

FILE: rtl/wall_law_roughness_friction.sv
// Rough-wall log-law bed friction, one grid cell per clock, fully pipelined.
// Throughput: one transaction per cycle; busy is low whenever reset is released.
// The depth is dominated by the 16 squaring stages of the log2 unit and the 35-stage divider.
// Reset (synchronous, active low) clears all valid bits and restores the configuration registers.
// Depends on wlrf_pkg.
module wall_law_roughness_friction
  import wlrf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_velocity,
  input  logic [23:0] in_water_depth,
  input  logic [23:0] in_rough_height,
  input  logic [31:0] in_force_in,
  output logic        out_valid,
  output logic [31:0] out_force_out,
  output logic [1:0]  out_cell_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [16:0] cfg_data
);

  // Configuration registers. The user must change them only while no transaction
  // is in flight; the block itself does not enforce this, and stages read them directly.
  logic        enable_r;
  logic [16:0] lf_r;
  logic [15:0] ik_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      lf_r     <= LF_ONE;
      ik_r     <= IK_RESET[15:0];
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_ENABLE:  enable_r <= cfg_data[0];
        CFG_LAYER:   lf_r     <= cfg_data;
        CFG_IKARMAN: ik_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // The receiver cannot stall and the pipeline never holds, so the block
  // takes a transaction in every cycle outside reset.
  assign busy = ~rst_n;

  logic accept;
  assign accept = start & ~busy;

  // Position of the leading one; an all-zero word reports zero.
  function automatic logic [4:0] msb_pos(input logic [30:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 1; i < 31; i++) begin
      if (x[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Valid bits and the control word travel down the whole pipeline.
  logic [PIPE_LEN-1:0] vld_r;
  ctl_t                ctl_r [0:PIPE_LEN-1];

  // Per-section data registers, indexed by the stage that loads them.
  logic [23:0] dist_r  [0:ST_DIFF+3];
  logic [23:0] depth_r [0:1];
  logic [23:0] ks_a_r;
  logic [23:0] vmag_a_r;
  logic [30:0] xt_b_r, xk_b_r;
  logic [46:0] vsq_b_r;
  logic [47:0] np0_c_r;
  logic [46:0] np1_c_r;
  logic [69:0] num_r   [3:ST_CAP-1];
  logic [4:0]  msbt_r  [2:ST_DIFF-1];
  logic [4:0]  msbk_r  [2:ST_DIFF-1];
  logic [30:0] xt_c_r, xk_c_r;
  logic [30:0] mt_r    [3:ST_DIFF-1];
  logic [30:0] mk_r    [3:ST_DIFF-1];
  logic [15:0] frt_r   [3:ST_DIFF-1];
  logic [15:0] frk_r   [3:ST_DIFF-1];
  logic [20:0] diff_r;
  logic [20:0] lnv_r;
  logic [24:0] uplus_r;
  logic [49:0] usq_r;
  logic [48:0] dp0_r, dp1_r;
  logic [73:0] den_r   [ST_CAP-1:PIPE_LEN-2];
  logic [85:0] rem_r   [ST_CAP:PIPE_LEN-2];
  logic [34:0] q_r     [ST_CAP:PIPE_LEN-1];
  logic        big_r   [ST_CAP:PIPE_LEN-1];

  // Combinational next values for the front end and the iterated units.
  logic [40:0] lfd_prod;
  logic [16:0] lf_lim;
  logic [23:0] vmag_nxt;
  logic [28:0] t_nxt;
  logic [61:0] sqt [N_SQ];
  logic [61:0] sqk [N_SQ];
  logic [20:0] lt_full, lk_full;
  logic [36:0] ln_prod, up_prod;
  logic [73:0] den_nxt;
  logic [85:0] nfull;
  logic        big_nxt;
  logic [109:0] dsub [N_QBITS];

  assign lf_lim   = lf_r[16] ? LF_ONE : lf_r;
  assign lfd_prod = {24'b0, lf_lim} * {17'b0, in_water_depth};
  assign vmag_nxt = in_velocity[23] ? (~in_velocity + 24'd1) : in_velocity;
  assign t_nxt    = 29'(dist_r[0]) * 29'd30;
  assign lt_full  = {msbt_r[ST_DIFF-1], frt_r[ST_DIFF-1]};
  assign lk_full  = {msbk_r[ST_DIFF-1], frk_r[ST_DIFF-1]};
  assign ln_prod  = {16'b0, diff_r} * {21'b0, LN2_Q16};
  assign up_prod  = {21'b0, ik_r} * {16'b0, lnv_r};
  assign den_nxt  = {dp1_r, 25'b0} + {25'b0, dp0_r};
  assign nfull    = {num_r[ST_CAP-1], 16'b0};
  assign big_nxt  = {23'b0, nfull} >= {den_r[ST_CAP-1], 35'b0};

  always_comb begin
    for (int k = 0; k < N_SQ; k++) begin
      sqt[k] = {31'b0, mt_r[ST_LOG0-1+k]} * {31'b0, mt_r[ST_LOG0-1+k]};
      sqk[k] = {31'b0, mk_r[ST_LOG0-1+k]} * {31'b0, mk_r[ST_LOG0-1+k]};
    end
  end

  // Restoring divider: stage j tries quotient bit 34-j against den << (34-j).
  always_comb begin
    for (int j = 0; j < N_QBITS; j++) begin
      dsub[j] = {24'b0, rem_r[ST_CAP+j]}
              - {1'b0, ({35'b0, den_r[ST_CAP+j]} << (N_QBITS-1-j))};
    end
  end

  // Control path: valid bits are cleared by reset; the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LEN-2:0], accept};
    end
  end

  // Data path: advances every cycle, no reset needed.
  always_ff @(posedge clk) begin
    // Stage 0: capture, layer distance, velocity magnitude.
    ctl_r[0].vneg     <= in_velocity[23];
    ctl_r[0].bypass   <= ~enable_r;
    ctl_r[0].degen    <= (in_rough_height == 24'd0);
    ctl_r[0].force_in <= in_force_in;
    dist_r[0]  <= lfd_prod[39:16];
    depth_r[0] <= in_water_depth;
    ks_a_r     <= in_rough_height;
    vmag_a_r   <= vmag_nxt;

    for (int i = 2; i < PIPE_LEN; i++) begin
      if (i != ST_DIFF+3) ctl_r[i] <= ctl_r[i-1];
    end
    // A clamped wall distance gives a zero log term, so the cell is degenerate.
    ctl_r[1] <= '{vneg: ctl_r[0].vneg, bypass: ctl_r[0].bypass,
                  degen: ctl_r[0].degen | (t_nxt < {5'b0, ks_a_r}),
                  force_in: ctl_r[0].force_in};
    // A zero uplus leaves no friction law to apply.
    ctl_r[ST_DIFF+3] <= '{vneg: ctl_r[ST_DIFF+2].vneg, bypass: ctl_r[ST_DIFF+2].bypass,
                          degen: ctl_r[ST_DIFF+2].degen | (uplus_r == 25'd0),
                          force_in: ctl_r[ST_DIFF+2].force_in};

    for (int i = 1; i <= ST_DIFF+3; i++) dist_r[i] <= dist_r[i-1];

    // Stage 1: log inputs and the velocity square.
    depth_r[1] <= depth_r[0];
    xt_b_r     <= {2'b0, t_nxt};
    xk_b_r     <= {7'b0, ks_a_r};
    vsq_b_r    <= 47'({24'b0, vmag_a_r} * {24'b0, vmag_a_r});

    // Stage 2: leading-one search, numerator partial products.
    msbt_r[2] <= msb_pos(xt_b_r);
    msbk_r[2] <= msb_pos(xk_b_r);
    xt_c_r    <= xt_b_r;
    xk_c_r    <= xk_b_r;
    np0_c_r   <= {24'b0, vsq_b_r[23:0]} * {24'b0, depth_r[1]};
    np1_c_r   <= {24'b0, vsq_b_r[46:24]} * {23'b0, depth_r[1]};

    // Stage 3: normalize to Q1.30, sum the numerator.
    mt_r[3]   <= xt_c_r << (5'd30 - msbt_r[2]);
    mk_r[3]   <= xk_c_r << (5'd30 - msbk_r[2]);
    frt_r[3]  <= '0;
    frk_r[3]  <= '0;
    msbt_r[3] <= msbt_r[2];
    msbk_r[3] <= msbk_r[2];
    num_r[3]  <= 70'({np1_c_r, 24'b0} + {24'b0, np0_c_r});

    // Squaring stages: one fraction bit of each log2 per stage.
    for (int k = 0; k < N_SQ; k++) begin
      mt_r[ST_LOG0+k]  <= sqt[k][61] ? sqt[k][61:31] : sqt[k][60:30];
      mk_r[ST_LOG0+k]  <= sqk[k][61] ? sqk[k][61:31] : sqk[k][60:30];
      frt_r[ST_LOG0+k] <= {frt_r[ST_LOG0-1+k][14:0], sqt[k][61]};
      frk_r[ST_LOG0+k] <= {frk_r[ST_LOG0-1+k][14:0], sqk[k][61]};
      msbt_r[ST_LOG0+k] <= msbt_r[ST_LOG0-1+k];
      msbk_r[ST_LOG0+k] <= msbk_r[ST_LOG0-1+k];
    end
    for (int i = 4; i < ST_CAP; i++) num_r[i] <= num_r[i-1];

    // Log difference, natural log, uplus, uplus squared.
    diff_r  <= (lt_full > lk_full) ? (lt_full - lk_full) : 21'd0;
    lnv_r   <= ln_prod[36:16];
    uplus_r <= up_prod[36:12];
    usq_r   <= {25'b0, uplus_r} * {25'b0, uplus_r};

    // Denominator: uplus^2 * dist in two halves, then their sum.
    dp0_r <= {24'b0, usq_r[24:0]} * {25'b0, dist_r[ST_DIFF+3]};
    dp1_r <= {24'b0, usq_r[49:25]} * {25'b0, dist_r[ST_DIFF+3]};
    den_r[ST_CAP-1] <= den_nxt;

    // Quotient range check ahead of the divider.
    den_r[ST_CAP] <= den_r[ST_CAP-1];
    rem_r[ST_CAP] <= nfull;
    q_r[ST_CAP]   <= '0;
    big_r[ST_CAP] <= big_nxt;

    for (int j = 0; j < N_QBITS; j++) begin
      q_r[ST_DIV0+j]   <= q_r[ST_CAP+j] | (35'(!dsub[j][109]) << (N_QBITS-1-j));
      big_r[ST_DIV0+j] <= big_r[ST_CAP+j];
    end
    for (int j = 0; j < N_QBITS-1; j++) begin
      rem_r[ST_DIV0+j] <= dsub[j][109] ? rem_r[ST_CAP+j] : dsub[j][85:0];
      den_r[ST_DIV0+j] <= den_r[ST_CAP+j];
    end
  end

  // Output stage: cap the friction term, apply it, saturate; bypass/degen keep force_in.
  ctl_t        ctl_z;
  logic [34:0] q_z;
  logic [33:0] term;
  logic [34:0] fext, res;
  logic [31:0] force_nxt;
  logic [1:0]  status_nxt;

  assign ctl_z = ctl_r[PIPE_LEN-1];
  assign q_z   = q_r[PIPE_LEN-1];
  assign term  = (big_r[PIPE_LEN-1] || (q_z > {1'b0, TERM_CAP})) ? TERM_CAP : q_z[33:0];
  assign fext  = {{3{ctl_z.force_in[31]}}, ctl_z.force_in};
  assign res   = ctl_z.vneg ? (fext + {1'b0, term}) : (fext - {1'b0, term});

  always_comb begin
    force_nxt  = ctl_z.force_in;
    status_nxt = STATUS_OK;
    if (ctl_z.bypass) begin
      status_nxt = STATUS_OK;
    end else if (ctl_z.degen) begin
      status_nxt = STATUS_DEGEN;
    end else if (!res[34] && (res[33:31] != 3'b000)) begin
      force_nxt  = 32'h7FFF_FFFF;
      status_nxt = STATUS_SAT;
    end else if (res[34] && (res[33:31] != 3'b111)) begin
      force_nxt  = 32'h8000_0000;
      status_nxt = STATUS_SAT;
    end else begin
      force_nxt = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    out_force_out   <= force_nxt;
    out_cell_status <= status_nxt;
  end

endmodule

FILE: rtl/wlrf_checker.sv
// Port-level checker for the bed friction block, bound to the top level.
// Depends on wlrf_pkg and on wall_law_roughness_friction.
module wlrf_checker
  import wlrf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_force_out,
  input logic [1:0]  out_cell_status
);

  // Every result comes from an earlier accepted transaction.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without matching transaction");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_status == STATUS_OK || out_cell_status == STATUS_DEGEN ||
                   out_cell_status == STATUS_SAT))
    else $error("undefined cell status");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_cell_status == STATUS_SAT) |->
      (out_force_out == 32'h7FFF_FFFF || out_force_out == 32'h8000_0000))
    else $error("saturated result not at a bound");

  a_reset: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind wall_law_roughness_friction wlrf_checker u_wlrf_checker (.*);
